>>> rtl/sdhf_pkg.sv
// Package for the streaming hash-set deduplication filter: sizes, types and hash.
package sdhf_pkg;

  // Table size; must be a power of two between 16 and 65536.
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int COUNT_OUT_W = 11;

  // Each table word carries a set tag next to the key. Tag zero never matches.
  localparam int EPOCH_W     = 8;
  localparam int MEM_W       = EPOCH_W + KEY_W;

  localparam logic [KEY_W-1:0]   HASH_MULT  = 32'h9E37_79B1;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } state_t;

  // Multiplicative hash: the low ADDR_W bits of the upper half of the low product word select the slot.
  function automatic logic [ADDR_W-1:0] home_slot(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] prod;
    prod = key * HASH_MULT;
    return prod[16 +: ADDR_W];
  endfunction

endpackage

>>> rtl/stream_dedup_hash_filter.sv
// Streaming hash-set deduplication filter with a linear-probing key table.
// Each accepted request reads its home slot and probes onward, one table read per probe through
// the single read port, for P probes (1 .. TABLE_DEPTH) until a hit, a free slot or a full table.
// No new request is taken until the current result is registered; a stalled output holds it.
// Reset: a clearing pass sweeps every table slot; in_ready stays low meanwhile.
// The same pass runs after every 255th request marked last, when the set tag wraps.
module stream_dedup_hash_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sdhf_pkg::KEY_W-1:0]    in_value,
  input  logic                                 in_last_of_set,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sdhf_pkg::KEY_W-1:0]    out_value_out,
  output logic                                 out_is_new,
  output logic [sdhf_pkg::COUNT_OUT_W-1:0]     out_unique_count,
  output logic                                 out_overflow,
  output logic                                 out_last_out
);
  import sdhf_pkg::*;

  state_t state_r, state_nxt;

  logic [KEY_W-1:0]   key_r;
  logic               last_r;
  logic [ADDR_W-1:0]  slot_r;
  logic [ADDR_W-1:0]  probes_r;
  logic [CNT_W-1:0]   count_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic               out_valid_r;

  // Table memory and its ports.
  logic [MEM_W-1:0]   mem [TABLE_DEPTH];
  logic [MEM_W-1:0]   rd_data_r;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [MEM_W-1:0]   wr_data;

  // Probe evaluation.
  logic [EPOCH_W-1:0] rd_tag;
  logic [KEY_W-1:0]   rd_key;
  logic               slot_used;
  logic               key_hit;
  logic               slot_free;
  logic               table_full;
  logic               decide;
  logic               out_free;
  logic               finish;
  logic               clr_done;
  logic [CNT_W-1:0]   count_inc;

  assign rd_tag     = rd_data_r[KEY_W +: EPOCH_W];
  assign rd_key     = rd_data_r[KEY_W-1:0];
  assign slot_used  = (rd_tag == epoch_r);
  assign key_hit    = slot_used && (rd_key == key_r);
  assign slot_free  = !slot_used;
  assign table_full = slot_used && !key_hit && (probes_r == {ADDR_W{1'b1}});
  assign decide     = key_hit || slot_free || table_full;
  assign out_free   = !out_valid_r || out_ready;
  assign finish     = (state_r == ST_CHECK) && decide && out_free;
  assign clr_done   = (clr_cnt_r == {ADDR_W{1'b1}});
  assign count_inc  = count_r + CNT_W'(slot_free);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (decide && out_free) begin
          if (last_r && (epoch_r == EPOCH_LAST)) state_nxt = ST_CLEAR;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Memory port control and handshake outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = slot_r;
    wr_en    = 1'b0;
    wr_addr  = slot_r;
    wr_data  = {epoch_r, key_r};
    case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = {EPOCH_NONE, {KEY_W{1'b0}}};
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_en    = in_valid;
        rd_addr  = home_slot(in_value);
      end
      ST_CHECK: begin
        if (!decide) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(slot_r + 1'b1);
        end
        wr_en = decide && out_free && slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Synchronous table memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // Request capture and probe stepping.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      key_r    <= in_value;
      last_r   <= in_last_of_set;
      slot_r   <= home_slot(in_value);
      probes_r <= '0;
    end else if (state_r == ST_CHECK && !decide) begin
      slot_r   <= ADDR_W'(slot_r + 1'b1);
      probes_r <= ADDR_W'(probes_r + 1'b1);
    end
  end

  // Set count, set tag and clearing sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      count_r   <= '0;
      epoch_r   <= EPOCH_FIRST;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= ADDR_W'(clr_cnt_r + 1'b1);
        if (clr_done) epoch_r <= EPOCH_FIRST;
      end
      if (finish) begin
        if (last_r) begin
          count_r <= '0;
          if (epoch_r != EPOCH_LAST) epoch_r <= EPOCH_W'(epoch_r + 1'b1);
        end else begin
          count_r <= count_inc;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_value_out    <= key_r;
      out_is_new       <= slot_free;
      out_unique_count <= COUNT_OUT_W'(count_inc);
      out_overflow     <= table_full;
      out_last_out     <= last_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/sdhf_checker.sv
// Port-level checker for the deduplication filter, bound to the top level.
module sdhf_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [sdhf_pkg::KEY_W-1:0]    out_value_out,
  input  logic                                 out_is_new,
  input  logic [sdhf_pkg::COUNT_OUT_W-1:0]     out_unique_count,
  input  logic                                 out_overflow
);
  import sdhf_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_out))
    else $error("result changed while stalled");

  // A value cannot be both stored and rejected for lack of room.
  a_new_xor_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_new && out_overflow))
    else $error("is_new and overflow both set");

  // A newly stored value means the set holds at least one entry.
  a_new_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_new |-> out_unique_count != '0)
    else $error("new value reported with zero count");

  // Overflow only happens when the table is completely full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_unique_count == COUNT_OUT_W'(TABLE_DEPTH))
    else $error("overflow reported with free slots");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind stream_dedup_hash_filter sdhf_checker u_sdhf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_value_out    (out_value_out),
  .out_is_new       (out_is_new),
  .out_unique_count (out_unique_count),
  .out_overflow     (out_overflow)
);
